/* rtl/core/i2cmbe_pkg.sv */
package i2cmbe_pkg;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_WAIT    = 5'd1,
    PH_ST_A    = 5'd2,
    PH_ST_B    = 5'd3,
    PH_ST_C    = 5'd4,
    PH_WB_LOW  = 5'd5,
    PH_WB_SET  = 5'd6,
    PH_WB_HIGH = 5'd7,
    PH_WA_LOW  = 5'd8,
    PH_WA_HIGH = 5'd9,
    PH_WA_END  = 5'd10,
    PH_RB_LOW  = 5'd11,
    PH_RB_HIGH = 5'd12,
    PH_RA_LOW  = 5'd13,
    PH_RA_HIGH = 5'd14,
    PH_RA_END  = 5'd15,
    PH_SP_A    = 5'd16,
    PH_SP_B    = 5'd17,
    PH_SP_C    = 5'd18
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic {
    REG_SLAVE_ADDR  = 1'b0,
    REG_DELAY_TICKS = 1'b1
  } reg_idx_e;

  localparam logic [6:0] SlaveAddrReset  = 7'h3C;
  localparam logic [7:0] DelayTicksReset = 8'd5;
  localparam logic [3:0] BitsPerByte     = 4'd8;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [7:0] tick_count;
    logic       in_transaction;
    logic       read_mode;
    logic       final_pending;
    logic       discarding;
    logic       scl;
    logic       sda;
    logic [7:0] held_byte;
    logic       addr_active;
    logic       abort_pending;
  } eng_state_t;

  // packed msb first so the lowest field sits in the lowest bits
  typedef struct packed {
    logic       done_res;
    logic       addr_nack;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       accepted;
    logic       ready_res;
    logic       sda_release;
    logic       scl_level;
  } eng_result_t;

  localparam eng_state_t EngStateReset = '{
    phase:          PH_IDLE,
    bit_count:      4'd0,
    shift_reg:      8'd0,
    tick_count:     8'd0,
    in_transaction: 1'b0,
    read_mode:      1'b0,
    final_pending:  1'b0,
    discarding:     1'b0,
    scl:            1'b1,
    sda:            1'b1,
    held_byte:      8'd0,
    addr_active:    1'b0,
    abort_pending:  1'b0
  };

endpackage

/* rtl/core/i2c_master_byte_engine_unit.sv */
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata, tuser (kind), tlast (last_byte)
// m_axis    out  m_axis_tvalid/tready        tdata (one result word per input word)
// cfg       in   cfg_we_i                    cfg_idx_i, cfg_data_i
//
// one word per clock unless stalled; state and result register update on the same edge
// the result register frees up in the cycle it is taken, so a stalled output only
// holds the input while the result is not taken
// reset puts the bus lines released high, engine idle, config registers at defaults
module i2c_master_byte_engine_unit
  import i2cmbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], sda_in[8], zero[15:9]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_release[1], ready_res[2], accepted[3], rx_valid[4],
  // rx_data[12:5], addr_nack[13], done_res[14], zero[15]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  eng_state_t  state_q, state_d;
  eng_result_t result_d;
  logic [14:0] result_q;
  logic        out_valid_q;
  logic [6:0]  slave_addr_q;
  logic [7:0]  delay_ticks_q;
  logic        in_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  i2cmbe_step u_step (
    .state_i       (state_q),
    .slave_addr_i  (slave_addr_q),
    .delay_ticks_i (delay_ticks_q),
    .kind_i        (s_axis_tuser),
    .data_byte_i   (s_axis_tdata[7:0]),
    .last_byte_i   (s_axis_tlast),
    .sda_in_i      (s_axis_tdata[8]),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q  <= SlaveAddrReset;
      delay_ticks_q <= DelayTicksReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SLAVE_ADDR:  slave_addr_q  <= cfg_data_i[6:0];
        REG_DELAY_TICKS: delay_ticks_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EngStateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

endmodule

/* rtl/core/i2cmbe_step.sv */
module i2cmbe_step
  import i2cmbe_pkg::*;
(
  input  eng_state_t  state_i,
  input  logic [6:0]  slave_addr_i,
  input  logic [7:0]  delay_ticks_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        sda_in_i,
  output eng_state_t  state_o,
  output eng_result_t result_o
);

  logic [7:0] full_len;
  logic [7:0] half_len;

  always_comb begin
    full_len = (delay_ticks_i == 8'd0) ? 8'd1 : delay_ticks_i;
    half_len = (full_len[7:1] == 7'd0) ? 8'd1 : {1'b0, full_len[7:1]};
  end

  always_comb begin
    eng_state_t  st;
    eng_result_t res;
    st  = state_i;
    res = '0;

    case (kind_e'(kind_i))
      KIND_TICK: begin
        if (st.phase != PH_IDLE && st.phase != PH_WAIT) begin
          if (st.tick_count > 8'd1) begin
            st.tick_count = st.tick_count - 8'd1;
          end else begin
            case (st.phase)
              PH_ST_A: begin
                st.sda = 1'b0;
                st.phase = PH_ST_B; st.tick_count = full_len;
              end
              PH_ST_B: begin
                st.scl = 1'b0;
                st.phase = PH_ST_C; st.tick_count = full_len;
              end
              PH_ST_C: begin
                st.addr_active = 1'b1;
                st.shift_reg = {slave_addr_i, st.read_mode};
                st.bit_count = 4'd0; st.scl = 1'b0;
                st.phase = PH_WB_LOW; st.tick_count = half_len;
              end
              PH_WB_LOW: begin
                st.sda = st.shift_reg[7];
                st.phase = PH_WB_SET; st.tick_count = half_len;
              end
              PH_WB_SET: begin
                st.scl = 1'b1;
                st.phase = PH_WB_HIGH; st.tick_count = full_len;
              end
              PH_WB_HIGH: begin
                st.shift_reg = {st.shift_reg[6:0], 1'b0};
                st.bit_count = st.bit_count + 4'd1;
                st.scl = 1'b0;
                if (st.bit_count < BitsPerByte) begin
                  st.phase = PH_WB_LOW; st.tick_count = half_len;
                end else begin
                  st.sda = 1'b1;
                  st.phase = PH_WA_LOW; st.tick_count = full_len;
                end
              end
              PH_WA_LOW: begin
                st.scl = 1'b1;
                st.phase = PH_WA_HIGH; st.tick_count = full_len;
              end
              PH_WA_HIGH: begin
                if (st.addr_active && sda_in_i) begin
                  st.abort_pending = 1'b1;
                  res.addr_nack = 1'b1;
                end
                st.scl = 1'b0; st.sda = 1'b1;
                st.phase = PH_WA_END; st.tick_count = full_len;
              end
              PH_WA_END: begin
                if (st.abort_pending) begin
                  st.addr_active = 1'b0;
                  st.sda = 1'b0;
                  st.phase = PH_SP_A; st.tick_count = full_len;
                end else if (st.addr_active) begin
                  st.addr_active = 1'b0;
                  st.bit_count = 4'd0; st.scl = 1'b0;
                  if (st.read_mode) begin
                    st.shift_reg = 8'd0; st.sda = 1'b1;
                    st.phase = PH_RB_LOW; st.tick_count = full_len;
                  end else begin
                    st.shift_reg = st.held_byte;
                    st.phase = PH_WB_LOW; st.tick_count = half_len;
                  end
                end else if (st.final_pending) begin
                  st.sda = 1'b0;
                  st.phase = PH_SP_A; st.tick_count = full_len;
                end else begin
                  st.phase = PH_WAIT; st.tick_count = 8'd0;
                end
              end
              PH_RB_LOW: begin
                st.scl = 1'b1;
                st.phase = PH_RB_HIGH; st.tick_count = full_len;
              end
              PH_RB_HIGH: begin
                st.shift_reg = {st.shift_reg[6:0], sda_in_i};
                st.bit_count = st.bit_count + 4'd1;
                st.scl = 1'b0;
                st.tick_count = full_len;
                if (st.bit_count < BitsPerByte) begin
                  st.phase = PH_RB_LOW;
                end else begin
                  res.rx_valid = 1'b1;
                  res.rx_data = st.shift_reg;
                  st.sda = st.final_pending;
                  st.phase = PH_RA_LOW;
                end
              end
              PH_RA_LOW: begin
                st.scl = 1'b1;
                st.phase = PH_RA_HIGH; st.tick_count = full_len;
              end
              PH_RA_HIGH: begin
                st.scl = 1'b0;
                st.phase = PH_RA_END; st.tick_count = full_len;
              end
              PH_RA_END: begin
                st.sda = 1'b1;
                if (st.final_pending) begin
                  st.sda = 1'b0;
                  st.phase = PH_SP_A; st.tick_count = full_len;
                end else begin
                  st.phase = PH_WAIT; st.tick_count = 8'd0;
                end
              end
              PH_SP_A: begin
                st.scl = 1'b1;
                st.phase = PH_SP_B; st.tick_count = full_len;
              end
              PH_SP_B: begin
                st.sda = 1'b1;
                st.phase = PH_SP_C; st.tick_count = full_len;
              end
              PH_SP_C: begin
                res.done_res = 1'b1;
                if (st.abort_pending) begin
                  st.abort_pending = 1'b0;
                  st.discarding = !st.final_pending;
                end
                st.in_transaction = st.discarding;
                st.phase = PH_IDLE; st.tick_count = 8'd0;
              end
              default: begin
                st.phase = PH_IDLE; st.tick_count = 8'd0;
              end
            endcase
          end
        end
      end
      KIND_WRITE, KIND_READ: begin
        if (st.phase == PH_IDLE) begin
          res.accepted = 1'b1;
          if (st.discarding) begin
            if (last_byte_i) begin
              st.discarding = 1'b0;
              st.in_transaction = 1'b0;
            end
          end else begin
            st.in_transaction = 1'b1;
            st.read_mode = (kind_e'(kind_i) == KIND_READ);
            st.final_pending = last_byte_i;
            st.held_byte = data_byte_i;
            st.abort_pending = 1'b0;
            st.scl = 1'b1; st.sda = 1'b1;
            st.phase = PH_ST_A; st.tick_count = full_len;
          end
        end else if (st.phase == PH_WAIT) begin
          res.accepted = 1'b1;
          st.final_pending = last_byte_i;
          st.bit_count = 4'd0; st.scl = 1'b0;
          if (st.read_mode) begin
            st.shift_reg = 8'd0; st.sda = 1'b1;
            st.phase = PH_RB_LOW; st.tick_count = full_len;
          end else begin
            st.shift_reg = data_byte_i;
            st.phase = PH_WB_LOW; st.tick_count = half_len;
          end
        end
      end
      default: begin
      end
    endcase

    res.scl_level   = st.scl;
    res.sda_release = st.sda;
    res.ready_res   = (st.phase == PH_IDLE) || (st.phase == PH_WAIT);

    state_o  = st;
    result_o = res;
  end

endmodule
